### src/swfe_pkg.sv
package swfe_pkg;

    localparam int WinLen     = 28;
    localparam int MinLenWords = 6;
    localparam int TdataWidth = 216;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 32;

    localparam logic [4:0]  FILL_LAST  = 5'(WinLen - 1);
    localparam logic [31:0] MIN_LEN    = 32'(MinLenWords);
    localparam logic [11:0] HDR_TAIL   = 12'(MinLenWords * 4);

    // reset values of the configuration registers
    localparam logic        RST_BIG_ENDIAN = 1'b1;
    localparam logic [31:0] RST_SYNC       = 32'h0564_0564;
    localparam logic [9:0]  RST_MAX_LEN    = 10'd1023;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_BIG_ENDIAN = 2'd0,
        CFG_SYNC       = 2'd1,
        CFG_MAX_LEN    = 2'd2
    } cfg_idx_t;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // byte i of the window sits at [i]
    typedef logic [WinLen-1:0][7:0] win_t;

    typedef struct packed {
        logic        match;
        logic [31:0] len_full;
        logic [31:0] utc_seconds;
        logic [31:0] utc_nanoseconds;
        logic [15:0] fiber_type_flags;
        logic [15:0] app_ident;
        logic [15:0] message_length;
        logic [15:0] check_field;
        logic [31:0] sequence_word;
    } hdr_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [9:0]  length_words;
        logic [31:0] utc_seconds;
        logic [31:0] utc_nanoseconds;
        logic [15:0] fiber_type_flags;
        logic [15:0] app_ident;
        logic [15:0] message_length;
        logic [15:0] check_field;
        logic [31:0] sequence_word;
        logic [31:0] frames_accepted;
    } res_t;

    function automatic logic [31:0] rd32(input win_t w, input int off, input logic be);
        logic [31:0] v;
        if (be) begin
            v = {w[off], w[off+1], w[off+2], w[off+3]};
        end else begin
            v = {w[off+3], w[off+2], w[off+1], w[off]};
        end
        return v;
    endfunction

    function automatic logic [15:0] rd16(input win_t w, input int off, input logic be);
        logic [15:0] v;
        if (be) begin
            v = {w[off], w[off+1]};
        end else begin
            v = {w[off+1], w[off]};
        end
        return v;
    endfunction

endpackage

### src/swfe_header_decode.sv
module swfe_header_decode (
    input  swfe_pkg::win_t  window,
    input  logic            big_endian,
    input  logic [31:0]     sync_pattern,
    input  logic [9:0]      max_length_words,
    output swfe_pkg::hdr_t  hdr
);

    logic [31:0] sync_word;
    logic [31:0] len_word;

    assign sync_word = swfe_pkg::rd32(window, 0, big_endian);
    assign len_word  = swfe_pkg::rd32(window, 4, big_endian);

    always_comb begin
        hdr.match = (sync_word == sync_pattern)
                 && (len_word >= swfe_pkg::MIN_LEN)
                 && (len_word <= {22'd0, max_length_words});
        hdr.len_full         = len_word;
        hdr.utc_seconds      = swfe_pkg::rd32(window, 8, big_endian);
        hdr.utc_nanoseconds  = swfe_pkg::rd32(window, 12, big_endian);
        hdr.fiber_type_flags = swfe_pkg::rd16(window, 16, big_endian);
        hdr.app_ident        = swfe_pkg::rd16(window, 18, big_endian);
        hdr.message_length   = swfe_pkg::rd16(window, 20, big_endian);
        hdr.check_field      = swfe_pkg::rd16(window, 22, big_endian);
        hdr.sequence_word    = swfe_pkg::rd32(window, 24, big_endian);
    end

endmodule

### src/sync_word_frame_extractor.sv
// Channel   | Dir | Handshake          | Content
// ----------+-----+--------------------+-------------------------------------------
// s_        | in  | s_tvalid/s_tready  | one capture byte per request
// m_        | out | m_tvalid/m_tready  | header result or payload byte
// cfg_      | in  | cfg_valid/cfg_ready| register index and write data
//
// One byte per cycle while s_tready is high: each request passes through the
// 28-byte window shift register and the parallel header decode into the result
// register, or the skid register behind a held result: a two-deep output that
// absorbs one stalled result; s_tready drops only while the skid register holds.
// Reset (aresetn low, synchronous) empties the window, ends any frame, zeroes
// the frame count and restores register defaults; window bytes are not cleared.
// cfg_ready is always high; writes take effect on the next cycle.
module sync_word_frame_extractor (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] byte_in

    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] payload_byte, [17:8] length_words, [49:18] utc_seconds,
    // [81:50] utc_nanoseconds, [97:82] fiber_type_flags, [113:98] app_ident,
    // [129:114] message_length, [145:130] check_field, [177:146] sequence_word,
    // [209:178] frames_accepted, [215:210] zero
    output logic [swfe_pkg::TdataWidth-1:0] m_tdata,
    output logic         m_tuser,     // [0] item_kind
    output logic         m_tlast,     // frame_end

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [swfe_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [swfe_pkg::CfgDataWidth-1:0] cfg_data
);

    // configuration registers
    logic        big_endian_reg;
    logic [31:0] sync_pattern_reg;
    logic [9:0]  max_len_reg;

    // hunt and frame state
    swfe_pkg::win_t win_reg, win_next;
    logic [4:0]  fill_reg, fill_next;
    logic        in_payload_reg, in_payload_next;
    logic [11:0] payload_left_reg, payload_left_next;
    logic [31:0] frame_counter_reg, frame_counter_next;

    // output stage
    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    swfe_pkg::res_t out_reg, out_next;
    swfe_pkg::res_t skid_reg, skid_next;

    logic           in_fire;
    logic           window_full;
    logic           hdr_accept;
    logic           res_valid;
    logic [11:0]    new_left;
    swfe_pkg::res_t res;
    swfe_pkg::hdr_t hdr;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;

    // window as it stands once this byte is shifted in
    assign win_next = {s_tdata, win_reg[swfe_pkg::WinLen-1:1]};

    swfe_header_decode u_decode (
        .window           (win_next),
        .big_endian       (big_endian_reg),
        .sync_pattern     (sync_pattern_reg),
        .max_length_words (max_len_reg),
        .hdr              (hdr)
    );

    assign window_full = !in_payload_reg && (fill_reg == swfe_pkg::FILL_LAST);
    assign hdr_accept  = in_fire && window_full && hdr.match;
    assign res_valid   = in_fire && (in_payload_reg || (window_full && hdr.match));
    // length is at most 1023 here, so len*4-24 fits in 12 bits
    assign new_left    = {hdr.len_full[9:0], 2'b00} - swfe_pkg::HDR_TAIL;

    // next hunt / frame state and the result of this byte
    always_comb begin
        fill_next          = fill_reg;
        in_payload_next    = in_payload_reg;
        payload_left_next  = payload_left_reg;
        frame_counter_next = frame_counter_reg;
        res                = '0;

        if (in_payload_reg) begin
            res.item_kind       = swfe_pkg::KIND_PAYLOAD;
            res.payload_byte    = s_tdata;
            res.frame_end       = (payload_left_reg == 12'd1);
            res.frames_accepted = frame_counter_reg;
        end else begin
            res.item_kind        = swfe_pkg::KIND_HEADER;
            res.frame_end        = (new_left == 12'd0);
            res.length_words     = hdr.len_full[9:0];
            res.utc_seconds      = hdr.utc_seconds;
            res.utc_nanoseconds  = hdr.utc_nanoseconds;
            res.fiber_type_flags = hdr.fiber_type_flags;
            res.app_ident        = hdr.app_ident;
            res.message_length   = hdr.message_length;
            res.check_field      = hdr.check_field;
            res.sequence_word    = hdr.sequence_word;
            res.frames_accepted  = frame_counter_reg + 32'd1;
        end

        if (in_fire) begin
            if (in_payload_reg) begin
                // count down; drop out of the frame on its last byte
                payload_left_next = payload_left_reg - 12'd1;
                if (payload_left_reg == 12'd1) begin
                    in_payload_next = 1'b0;
                end
            end else if (window_full) begin
                if (hdr.match) begin
                    frame_counter_next = frame_counter_reg + 32'd1;
                    payload_left_next  = new_left;
                    in_payload_next    = (new_left != 12'd0);
                    fill_next          = 5'd0;
                end
                // rejected: hold fill, the shift already slid the window
            end else begin
                fill_next = fill_reg + 5'd1;
            end
        end
    end

    // result register with skid register behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end else if (res_valid) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg    <= swfe_pkg::RST_BIG_ENDIAN;
            sync_pattern_reg  <= swfe_pkg::RST_SYNC;
            max_len_reg       <= swfe_pkg::RST_MAX_LEN;
            fill_reg          <= 5'd0;
            in_payload_reg    <= 1'b0;
            payload_left_reg  <= 12'd0;
            frame_counter_reg <= 32'd0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    swfe_pkg::CFG_BIG_ENDIAN: big_endian_reg   <= cfg_data[0];
                    swfe_pkg::CFG_SYNC:       sync_pattern_reg <= cfg_data;
                    swfe_pkg::CFG_MAX_LEN:    max_len_reg      <= cfg_data[9:0];
                    default: ;
                endcase
            end
            fill_reg          <= fill_next;
            in_payload_reg    <= in_payload_next;
            payload_left_reg  <= payload_left_next;
            frame_counter_reg <= frame_counter_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (in_fire && !in_payload_reg) begin
            win_reg <= win_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.item_kind;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {6'd0,
                       out_reg.frames_accepted,
                       out_reg.sequence_word,
                       out_reg.check_field,
                       out_reg.message_length,
                       out_reg.app_ident,
                       out_reg.fiber_type_flags,
                       out_reg.utc_nanoseconds,
                       out_reg.utc_seconds,
                       out_reg.length_words,
                       out_reg.payload_byte};

    // skid register only fills behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid without result register");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= swfe_pkg::FILL_LAST)
        else $error("window fill out of range");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (payload_left_reg != 12'd0) && (fill_reg == 5'd0))
        else $error("payload state with empty count or filled window");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_accept |=> frame_counter_reg == $past(frame_counter_reg) + 32'd1)
        else $error("frame count did not advance on header");

    a_no_result_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !out_valid_reg) |=> out_valid_reg)
        else $error("result dropped");

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index past the end of the list; writes to it must be dropped.
    localparam logic [swfe_pkg::CfgIdxWidth-1:0] CfgIdxSpare = 2'd3;
    localparam int unsigned HdrBytes = 28;
    localparam int unsigned ShortestFrame = 6;
    // A random frame sized to the length limit is only drawn when the limit is this low.
    localparam int unsigned LongestRandom = 64;

    // One capture byte on its way in. A header row of the directed table
    // carries its typed-in result on the last header byte.
    typedef struct packed {
        logic [7:0]      b;
        logic            typed;
        swfe_pkg::res_t  want;
    } byte_req_t;

    // Directed frame: count is the frame count on the header result, 0 when
    // the header must be rejected.
    typedef struct packed {
        logic [7:0]  junk;
        logic [31:0] sync_flip;
        logic [31:0] len;
        logic [31:0] sec;
        logic [31:0] nsec;
        logic [15:0] fiber;
        logic [15:0] app;
        logic [15:0] msg_len;
        logic [15:0] check;
        logic [31:0] seq;
        logic [31:0] count;
    } frame_row_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [7:0]                            s_tdata;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [swfe_pkg::TdataWidth-1:0]       m_tdata;
    logic                                  m_tuser;
    logic                                  m_tlast;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [swfe_pkg::CfgIdxWidth-1:0]      cfg_index;
    logic [swfe_pkg::CfgDataWidth-1:0]     cfg_data;

    // Deframer copy: hunt window, frame state and register shadows.
    logic [7:0]  hunt_win [HdrBytes];
    int unsigned hunt_fill;
    bit          in_frame;
    logic [11:0] bytes_left;
    logic [31:0] frame_count;
    logic        cfg_be;
    logic [31:0] cfg_sync;
    logic [9:0]  cfg_max;

    swfe_pkg::res_t deframed_q [$];
    byte_req_t      tx_q [$];

    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned headers_seen;
    int unsigned payload_seen;
    int unsigned settings_run;
    int unsigned big_left;
    int unsigned hold_req;
    bit          tx_idle;
    bit          rx_idle;

    frame_row_t rows [12] = '{
        // all-ones header fields, empty payload
        '{8'd0, 32'h0, 32'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd1},
        // all-zero fields behind filler bytes, one payload word
        '{8'd3, 32'h0, 32'd7, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'd2},
        // short lengths
        '{8'd0, 32'h0, 32'd5, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd0},
        '{8'd0, 32'h0, 32'd0, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd0},
        // long lengths, including two whose low ten bits would pass
        '{8'd0, 32'h0, 32'd1024, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd0},
        '{8'd0, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd0},
        '{8'd0, 32'h0, 32'h0001_0008, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd0},
        // sync word off in its lowest and highest bit, then a good frame behind filler
        '{8'd0, 32'h0000_0001, 32'd8, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd0},
        '{8'd0, 32'h8000_0000, 32'd8, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd0},
        '{8'd1, 32'h0, 32'd9, 32'h1234_5678, 32'h9ABC_DEF0, 16'h8001, 16'h0102,
          16'h0040, 16'hBEEF, 32'h7654_3210, 32'd3},
        // longer payload, then an empty one behind filler bytes
        '{8'd0, 32'h0, 32'd40, 32'h0102_0304, 32'h1122_3344, 16'hA0A1, 16'hB0B1,
          16'hC0C1, 16'hD0D1, 32'hE0E1_E2E3, 32'd4},
        '{8'd2, 32'h0, 32'd6, 32'h8000_0001, 32'h4000_0002, 16'h2003, 16'h1004,
          16'h0806, 16'h0C07, 32'h0A0B_0C0D, 32'd5}
    };

    sync_word_frame_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1ns aclk = ~aclk;

    // Read nb bytes of the hunt window from off in the configured byte order.
    function automatic logic [31:0] win_word(input int unsigned off, input int unsigned nb);
        logic [31:0] v;
        v = '0;
        for (int unsigned i = 0; i < nb; i++) begin
            if (cfg_be) begin
                v = (v << 8) | 32'(hunt_win[off + i]);
            end else begin
                v = v | (32'(hunt_win[off + i]) << (8 * i));
            end
        end
        return v;
    endfunction

    // Advance the deframer by one capture byte; return 1 when a result comes out.
    function automatic bit deframe_byte(input logic [7:0] b, output swfe_pkg::res_t r);
        logic [31:0] len;
        r = '0;
        if (in_frame) begin
            r.item_kind    = swfe_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            if (bytes_left != 0) bytes_left--;
            if (bytes_left == 0) begin
                in_frame    = 1'b0;
                r.frame_end = 1'b1;
            end
            r.frames_accepted = frame_count;
            return 1'b1;
        end
        if (hunt_fill >= HdrBytes) hunt_fill = HdrBytes - 1;
        hunt_win[hunt_fill] = b;
        hunt_fill++;
        if (hunt_fill < HdrBytes) return 1'b0;
        len = win_word(4, 4);
        if (win_word(0, 4) != cfg_sync || len < ShortestFrame || len > {22'd0, cfg_max}) begin
            // slide by one byte and keep hunting
            for (int unsigned i = 0; i < HdrBytes - 1; i++) hunt_win[i] = hunt_win[i + 1];
            hunt_fill = HdrBytes - 1;
            return 1'b0;
        end
        frame_count++;
        bytes_left = 12'(len * 4 - 24);
        in_frame   = bytes_left != 0;
        hunt_fill  = 0;
        r.item_kind        = swfe_pkg::KIND_HEADER;
        r.frame_end        = !in_frame;
        r.length_words     = len[9:0];
        r.utc_seconds      = win_word(8, 4);
        r.utc_nanoseconds  = win_word(12, 4);
        r.fiber_type_flags = 16'(win_word(16, 2));
        r.app_ident        = 16'(win_word(18, 2));
        r.message_length   = 16'(win_word(20, 2));
        r.check_field      = 16'(win_word(22, 2));
        r.sequence_word    = win_word(24, 4);
        r.frames_accepted  = frame_count;
        return 1'b1;
    endfunction

    task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Check each result against the oldest expectation.
    always @(posedge aclk) begin
        swfe_pkg::res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (deframed_q.size() == 0) begin
                $error("result with nothing expected: kind %0b tdata 0x%0h", m_tuser, m_tdata);
                errors++;
            end else begin
                w = deframed_q.pop_front();
                cmp("item_kind", 32'(w.item_kind), 32'(m_tuser));
                cmp("payload_byte", 32'(w.payload_byte), 32'(m_tdata[7:0]));
                cmp("frame_end", 32'(w.frame_end), 32'(m_tlast));
                cmp("length_words", 32'(w.length_words), 32'(m_tdata[17:8]));
                cmp("utc_seconds", w.utc_seconds, m_tdata[49:18]);
                cmp("utc_nanoseconds", w.utc_nanoseconds, m_tdata[81:50]);
                cmp("fiber_type_flags", 32'(w.fiber_type_flags), 32'(m_tdata[97:82]));
                cmp("app_ident", 32'(w.app_ident), 32'(m_tdata[113:98]));
                cmp("message_length", 32'(w.message_length), 32'(m_tdata[129:114]));
                cmp("check_field", 32'(w.check_field), 32'(m_tdata[145:130]));
                cmp("sequence_word", w.sequence_word, m_tdata[177:146]);
                cmp("frames_accepted", w.frames_accepted, m_tdata[209:178]);
                cmp("tdata_pad", 32'd0, 32'(m_tdata[215:210]));
                if (w.item_kind == swfe_pkg::KIND_HEADER) headers_seen++;
                else payload_seen++;
            end
        end
    end

    // Result side: while rx_idle is set, stall a random number of cycles per result, or hold off
    // for a long stretch when asked, counting the cycles here.
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 16) : 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Offer one byte, after a random gap while tx_idle is set; predict its result once accepted.
    task automatic send_byte(input byte_req_t req);
        swfe_pkg::res_t r;
        bit             got;
        int unsigned    gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req.b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        got = deframe_byte(req.b, r);
        if (req.typed) deframed_q.push_back(req.want);
        else if (got) deframed_q.push_back(r);
    endtask

    task automatic drain_tx();
        while (tx_q.size() != 0) send_byte(tx_q.pop_front());
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic wait_quiet();
        int unsigned waited;
        waited = 0;
        while (deframed_q.size() != 0 && waited < 100000) begin
            @(negedge aclk);
            waited++;
        end
        if (deframed_q.size() != 0) begin
            $error("%0d expected results never arrived", deframed_q.size());
            errors++;
            deframed_q.delete();
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [swfe_pkg::CfgIdxWidth-1:0] idx,
                             input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            swfe_pkg::CFG_BIG_ENDIAN: cfg_be   = val[0];
            swfe_pkg::CFG_SYNC:       cfg_sync = val;
            swfe_pkg::CFG_MAX_LEN:    cfg_max  = val[9:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_word(input logic [31:0] v, input int unsigned nb);
        byte_req_t q;
        q = '0;
        for (int unsigned i = 0; i < nb; i++) begin
            q.b = cfg_be ? v[8 * (nb - 1 - i) +: 8] : v[8 * i +: 8];
            tx_q.push_back(q);
        end
    endtask

    // Filler ahead of a directed header never holds the first sync byte.
    task automatic queue_fill(input int unsigned n, input bit tame);
        logic [7:0] b;
        for (int unsigned i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (tame && b == 8'h05) b = 8'h06;
            queue_word({24'd0, b}, 1);
        end
    endtask

    // Payload opens with the byte extremes, then random bytes.
    task automatic queue_payload(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            queue_word(i == 0 ? 32'h00 : i == 1 ? 32'hFF : 32'($urandom) & 32'hFF, 1);
        end
    endtask

    task automatic queue_header(input frame_row_t f, input logic [31:0] sync);
        queue_word(sync, 4);
        queue_word(f.len, 4);
        queue_word(f.sec, 4);
        queue_word(f.nsec, 4);
        queue_word({16'd0, f.fiber}, 2);
        queue_word({16'd0, f.app}, 2);
        queue_word({16'd0, f.msg_len}, 2);
        queue_word({16'd0, f.check}, 2);
        queue_word(f.seq, 4);
    endtask

    // Random frame: most are well formed, the rest carry a bad length, a
    // damaged sync word, or are plain noise.
    task automatic queue_random_frame(input int unsigned kind);
        frame_row_t  f;
        logic [31:0] sync;
        int unsigned top;
        bit          accepted;
        f = '0;
        {f.sec, f.nsec, f.seq} = {$urandom, $urandom, $urandom};
        {f.fiber, f.app, f.msg_len, f.check} = {$urandom, $urandom};
        sync = cfg_sync;
        top  = cfg_max > 16 ? 16 : cfg_max;
        if (top < ShortestFrame) top = ShortestFrame;
        f.len = $urandom_range(ShortestFrame, top);
        if (kind <= 5 && big_left != 0 && cfg_max >= ShortestFrame
                && cfg_max <= LongestRandom && $urandom_range(0, 19) == 0) begin
            f.len = cfg_max;
            big_left--;
        end
        if (kind == 6) f.len = $urandom_range(0, ShortestFrame - 1);
        if (kind == 7) begin
            if (cfg_max < 1023 && $urandom_range(0, 1) == 1) begin
                f.len = $urandom_range(cfg_max + 1, 1023);
            end else begin
                f.len = $urandom_range(1024, 32'hFFFF_FFFF);
            end
        end
        if (kind == 8) sync = sync ^ (32'd1 << $urandom_range(0, 31));
        if (kind == 9) begin
            queue_fill($urandom_range(1, 40), 1'b0);
        end else begin
            queue_fill($urandom_range(0, 6), 1'b0);
            queue_header(f, sync);
            accepted = kind <= 5 && f.len >= ShortestFrame && f.len <= {22'd0, cfg_max};
            if (accepted) queue_payload(f.len * 4 - 24);
        end
    endtask

    task automatic run_phase(input logic be, input logic [31:0] sync, input logic [9:0] max_len,
                             input bit txi, input bit rxi, input int unsigned target,
                             input bit squeeze);
        frame_row_t f;
        wait_quiet();
        write_reg(swfe_pkg::CFG_BIG_ENDIAN, {31'($urandom), be});
        write_reg(swfe_pkg::CFG_SYNC, sync);
        write_reg(swfe_pkg::CFG_MAX_LEN, {22'($urandom), max_len});
        settings_run++;
        tx_idle = txi;
        rx_idle = rxi;
        if (squeeze) begin
            // long frame sent back to back while the result side holds off
            f     = '0;
            f.len = 80;
            queue_header(f, cfg_sync);
            queue_payload(f.len * 4 - 24);
        end
        while (tx_q.size() < target) queue_random_frame($urandom_range(0, 9));
        if (squeeze) hold_req = 300;
        drain_tx();
    endtask

    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        swfe_pkg::res_t w;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = swfe_pkg::CFG_BIG_ENDIAN;
        cfg_data  = '0;
        hunt_fill = 0;
        in_frame  = 1'b0;
        bytes_left  = '0;
        frame_count = '0;
        cfg_be    = 1'b1;
        cfg_sync  = 32'h0564_0564;
        cfg_max   = 10'd1023;
        errors    = 0;
        bytes_sent   = 0;
        headers_seen = 0;
        payload_seen = 0;
        settings_run = 1;
        big_left  = 1;
        hold_req  = 0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        for (int unsigned i = 0; i < HdrBytes; i++) hunt_win[i] = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table under the reset register values.
        foreach (rows[i]) begin
            queue_fill(rows[i].junk, 1'b1);
            queue_header(rows[i], cfg_sync ^ rows[i].sync_flip);
            if (rows[i].count != 0) begin
                w = '0;
                w.item_kind        = swfe_pkg::KIND_HEADER;
                w.frame_end        = rows[i].len == ShortestFrame;
                w.length_words     = rows[i].len[9:0];
                w.utc_seconds      = rows[i].sec;
                w.utc_nanoseconds  = rows[i].nsec;
                w.fiber_type_flags = rows[i].fiber;
                w.app_ident        = rows[i].app;
                w.message_length   = rows[i].msg_len;
                w.check_field      = rows[i].check;
                w.sequence_word    = rows[i].seq;
                w.frames_accepted  = rows[i].count;
                tx_q[tx_q.size() - 1].typed = 1'b1;
                tx_q[tx_q.size() - 1].want  = w;
                queue_payload(rows[i].len * 4 - 24);
            end
        end
        drain_tx();

        // Random phases over register extremes and idle patterns.
        run_phase(1'b0, $urandom, 10'd1023, 1'b1, 1'b1, 110, 1'b0);
        run_phase(1'b1, 32'h0000_0000, 10'd6, 1'b0, 1'b0, 110, 1'b0);
        run_phase(1'b0, 32'hFFFF_FFFF, 10'($urandom_range(6, 1023)), 1'b1, 1'b0, 110, 1'b0);
        run_phase(1'b1, 32'h0564_0564, 10'd0, 1'b0, 1'b1, 50, 1'b0);
        run_phase(1'b0, 32'h0564_0564, 10'd5, 1'b1, 1'b1, 50, 1'b0);
        run_phase(1'b0, 32'h0564_0564, 10'd1023, 1'b0, 1'b1, 300, 1'b1);
        // a write to the spare index must leave every register as it was
        wait_quiet();
        write_reg(CfgIdxSpare, $urandom);
        run_phase(1'($urandom), $urandom, 10'($urandom_range(6, 40)), 1'b1, 1'b1, 110, 1'b0);
        run_phase(1'b1, 32'h0564_0564, 10'd1023, 1'b1, 1'b1, 110, 1'b0);

        wait_quiet();
        $display("Fed %0d capture bytes through %0d register settings", bytes_sent, settings_run);
        $display("Checked %0d header results and %0d payload bytes", headers_seen, payload_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
